/* rtl/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the page-addressed LCD controller with
// display RAM: item structs, mode and command codes, geometry, control state.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int RAM_COLUMNS   = 132;
    localparam int RAM_PAGES     = 9;
    localparam int VISIBLE_WIDTH = 96;
    localparam int VISIBLE_ROWS  = 64;

    localparam int RAM_DEPTH = RAM_PAGES * RAM_COLUMNS;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int COL_W     = 8;
    localparam int PAGE_W    = 4;
    localparam int LINE_W    = $clog2(VISIBLE_ROWS);

    localparam logic [COL_W-1:0]  LAST_COLUMN = COL_W'(RAM_COLUMNS - 1);
    localparam logic [PAGE_W-1:0] LAST_PAGE   = PAGE_W'(RAM_PAGES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(RAM_DEPTH - 1);

    // access modes
    localparam logic [2:0] MODE_CMD_WRITE   = 3'd0;
    localparam logic [2:0] MODE_DATA_WRITE  = 3'd1;
    localparam logic [2:0] MODE_STATUS_READ = 3'd2;
    localparam logic [2:0] MODE_DATA_READ   = 3'd3;
    localparam logic [2:0] MODE_PIXEL_QUERY = 3'd4;

    localparam logic [7:0] STATUS_VALUE = 8'h00;

    // command bytes
    localparam logic [7:0] CMD_DISPLAY_OFF   = 8'hAE;
    localparam logic [7:0] CMD_DISPLAY_ON    = 8'hAF;
    localparam logic [7:0] CMD_START_LO      = 8'h40;
    localparam logic [7:0] CMD_START_HI      = 8'h7F;
    localparam logic [7:0] CMD_COL_LOW_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_LOW_HI    = 8'h0F;
    localparam logic [7:0] CMD_COL_HIGH_LO   = 8'h10;
    localparam logic [7:0] CMD_COL_HIGH_HI   = 8'h1F;
    localparam logic [7:0] CMD_PAGE_LO       = 8'hB0;
    localparam logic [7:0] CMD_PAGE_HI       = 8'hBF;
    localparam logic [7:0] CMD_SEG_NORMAL    = 8'hA0;
    localparam logic [7:0] CMD_SEG_REVERSE   = 8'hA1;
    localparam logic [7:0] CMD_ALL_ON_OFF    = 8'hA4;
    localparam logic [7:0] CMD_ALL_ON_ON     = 8'hA5;
    localparam logic [7:0] CMD_RMW_BEGIN     = 8'hE0;
    localparam logic [7:0] CMD_RMW_END       = 8'hEE;
    localparam logic [7:0] CMD_COM_LO        = 8'hC0;
    localparam logic [7:0] CMD_COM_HI        = 8'hCF;
    localparam logic [7:0] CMD_CONTRAST      = 8'h81;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic [5:0] pixel_row;
        logic [6:0] pixel_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pixel_on;
        logic [5:0] contrast_level;
    } t_out_item;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef enum logic [1:0] {
        RSP_ZERO,
        RSP_READ,
        RSP_PIXEL_RAM,
        RSP_PIXEL_ONE
    } t_rsp_kind;

    typedef struct packed {
        logic clear_en;
        logic accept;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

/* rtl/lcc_ram.sv */
// ----------------------------------------------------------------------------
// lcc_ram
// Generic single-port RAM with one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module lcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lcc_ctrl.sv */
// ----------------------------------------------------------------------------
// lcc_ctrl
// Controller: sweeps the display RAM to zero after reset, then takes one
// item per cycle.
// ----------------------------------------------------------------------------
module lcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lcc_pkg::t_dp_status i_status,
    output logic                o_busy,
    output lcc_pkg::t_dp_cmd    o_cmd
);

    lcc_pkg::t_state r_state;
    lcc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lcc_pkg::ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = lcc_pkg::ST_RUN;
                end
            end
            lcc_pkg::ST_RUN: begin
                n_state = lcc_pkg::ST_RUN;
            end
            default: begin
                n_state = lcc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_busy         = 1'b1;
        o_cmd.clear_en = 1'b0;
        o_cmd.accept   = 1'b0;
        case (r_state)
            lcc_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            lcc_pkg::ST_RUN: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/lcc_datapath.sv */
// ----------------------------------------------------------------------------
// lcc_datapath
// Pointers and mode flags, command decode, RAM address and write data,
// pixel mapping and the result register.
// ----------------------------------------------------------------------------
module lcc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcc_pkg::t_dp_cmd    i_cmd,
    input  lcc_pkg::t_in_item   i_item,
    output lcc_pkg::t_dp_status o_status,
    output logic                o_strobe,
    output lcc_pkg::t_out_item  o_result
);

    localparam int AW = lcc_pkg::ADDR_W;
    localparam int CW = lcc_pkg::COL_W;
    localparam int PW = lcc_pkg::PAGE_W;
    localparam int LW = lcc_pkg::LINE_W;

    logic [AW-1:0] r_clear_addr;
    logic [CW-1:0] r_column;
    logic [CW-1:0] n_column;
    logic [PW-1:0] r_page;
    logic [PW-1:0] n_page;
    logic [LW-1:0] r_start_line;
    logic [LW-1:0] n_start_line;
    logic          r_display_on;
    logic          n_display_on;
    logic          r_all_on;
    logic          n_all_on;
    logic          r_seg_rev;
    logic          n_seg_rev;
    logic          r_com_rev;
    logic          n_com_rev;
    logic          r_modify;
    logic          n_modify;
    logic          r_expect_contrast;
    logic          n_expect_contrast;
    logic [5:0]    r_contrast;
    logic [5:0]    n_contrast;

    logic                r_rsp_valid;
    lcc_pkg::t_rsp_kind  r_rsp_kind;
    lcc_pkg::t_rsp_kind  n_rsp_kind;
    logic [2:0]          r_bit_sel;

    logic [CW-1:0] col_nibble;
    logic [LW-1:0] com;
    logic [LW-1:0] line;
    logic [CW-1:0] pix_col;
    logic [CW-1:0] ram_col;
    logic          pix_valid;
    logic [AW-1:0] ptr_addr;
    logic [AW-1:0] pix_addr;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // pointer address and pixel address
    assign ptr_addr = AW'(r_page) * AW'(lcc_pkg::RAM_COLUMNS) + AW'(r_column);
    assign com      = r_com_rev ? ~i_item.pixel_row : i_item.pixel_row;
    assign line     = com + r_start_line;
    assign pix_col  = CW'(i_item.pixel_column);
    assign ram_col  = r_seg_rev ? (lcc_pkg::LAST_COLUMN - pix_col) : pix_col;
    assign pix_addr = AW'(line[LW-1:3]) * AW'(lcc_pkg::RAM_COLUMNS) + AW'(ram_col);

    always_comb begin
        pix_valid = 1'b1;
        if (pix_col >= CW'(lcc_pkg::VISIBLE_WIDTH)) begin
            pix_valid = 1'b0;
        end
        if (r_seg_rev && (pix_col > lcc_pkg::LAST_COLUMN)) begin
            pix_valid = 1'b0;
        end
        if (ram_col >= CW'(lcc_pkg::RAM_COLUMNS)) begin
            pix_valid = 1'b0;
        end
    end

    always_comb begin
        n_column          = r_column;
        n_page            = r_page;
        n_start_line      = r_start_line;
        n_display_on      = r_display_on;
        n_all_on          = r_all_on;
        n_seg_rev         = r_seg_rev;
        n_com_rev         = r_com_rev;
        n_modify          = r_modify;
        n_expect_contrast = r_expect_contrast;
        n_contrast        = r_contrast;
        n_rsp_kind        = lcc_pkg::RSP_ZERO;
        col_nibble        = r_column;
        ram_we            = 1'b0;
        ram_addr          = ptr_addr;
        ram_wdata         = i_item.data_byte;

        if (i_cmd.clear_en) begin
            ram_we    = 1'b1;
            ram_addr  = r_clear_addr;
            ram_wdata = 8'h00;
        end else if (i_cmd.accept) begin
            if (((i_item.mode == lcc_pkg::MODE_CMD_WRITE)
                    || (i_item.mode == lcc_pkg::MODE_DATA_WRITE)) && r_expect_contrast) begin
                n_contrast        = i_item.data_byte[5:0];
                n_expect_contrast = 1'b0;
            end else begin
                case (i_item.mode)
                    lcc_pkg::MODE_CMD_WRITE: begin
                        case (i_item.data_byte) inside
                            lcc_pkg::CMD_DISPLAY_OFF, lcc_pkg::CMD_DISPLAY_ON: begin
                                n_display_on = i_item.data_byte[0];
                            end
                            [lcc_pkg::CMD_START_LO:lcc_pkg::CMD_START_HI]: begin
                                n_start_line = i_item.data_byte[LW-1:0];
                            end
                            [lcc_pkg::CMD_COL_LOW_LO:lcc_pkg::CMD_COL_LOW_HI]: begin
                                col_nibble = {r_column[7:4], i_item.data_byte[3:0]};
                                n_column   = (col_nibble > lcc_pkg::LAST_COLUMN)
                                           ? lcc_pkg::LAST_COLUMN : col_nibble;
                            end
                            [lcc_pkg::CMD_COL_HIGH_LO:lcc_pkg::CMD_COL_HIGH_HI]: begin
                                col_nibble = {i_item.data_byte[3:0], r_column[3:0]};
                                n_column   = (col_nibble > lcc_pkg::LAST_COLUMN)
                                           ? lcc_pkg::LAST_COLUMN : col_nibble;
                            end
                            [lcc_pkg::CMD_PAGE_LO:lcc_pkg::CMD_PAGE_HI]: begin
                                n_page = (i_item.data_byte[3:0] > lcc_pkg::LAST_PAGE)
                                       ? lcc_pkg::LAST_PAGE : i_item.data_byte[3:0];
                            end
                            lcc_pkg::CMD_SEG_NORMAL, lcc_pkg::CMD_SEG_REVERSE: begin
                                n_seg_rev = i_item.data_byte[0];
                            end
                            lcc_pkg::CMD_ALL_ON_OFF, lcc_pkg::CMD_ALL_ON_ON: begin
                                n_all_on = i_item.data_byte[0];
                            end
                            lcc_pkg::CMD_RMW_BEGIN: begin
                                n_modify = 1'b1;
                            end
                            lcc_pkg::CMD_RMW_END: begin
                                n_modify = 1'b0;
                            end
                            [lcc_pkg::CMD_COM_LO:lcc_pkg::CMD_COM_HI]: begin
                                n_com_rev = i_item.data_byte[3];
                            end
                            lcc_pkg::CMD_CONTRAST: begin
                                n_expect_contrast = 1'b1;
                            end
                            default: begin
                                n_expect_contrast = r_expect_contrast;
                            end
                        endcase
                    end
                    lcc_pkg::MODE_DATA_WRITE: begin
                        ram_we = 1'b1;
                        if (r_page >= lcc_pkg::LAST_PAGE) begin
                            ram_wdata = {7'd0, i_item.data_byte[0]};
                        end
                        if (r_column < lcc_pkg::LAST_COLUMN) begin
                            n_column = r_column + CW'(1);
                        end
                    end
                    lcc_pkg::MODE_STATUS_READ: begin
                        n_rsp_kind = lcc_pkg::RSP_ZERO;
                    end
                    lcc_pkg::MODE_DATA_READ: begin
                        n_rsp_kind = lcc_pkg::RSP_READ;
                        if (!r_modify && (r_column < lcc_pkg::LAST_COLUMN)) begin
                            n_column = r_column + CW'(1);
                        end
                    end
                    lcc_pkg::MODE_PIXEL_QUERY: begin
                        ram_addr = pix_addr;
                        if (!r_display_on) begin
                            n_rsp_kind = lcc_pkg::RSP_ZERO;
                        end else if (r_all_on) begin
                            n_rsp_kind = lcc_pkg::RSP_PIXEL_ONE;
                        end else if (pix_valid) begin
                            n_rsp_kind = lcc_pkg::RSP_PIXEL_RAM;
                        end
                    end
                    default: begin
                        n_rsp_kind = lcc_pkg::RSP_ZERO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_addr      <= '0;
            r_column          <= '0;
            r_page            <= '0;
            r_start_line      <= '0;
            r_display_on      <= 1'b0;
            r_all_on          <= 1'b0;
            r_seg_rev         <= 1'b0;
            r_com_rev         <= 1'b0;
            r_modify          <= 1'b0;
            r_expect_contrast <= 1'b0;
            r_contrast        <= '0;
            r_rsp_valid       <= 1'b0;
            r_rsp_kind        <= lcc_pkg::RSP_ZERO;
        end else begin
            if (i_cmd.clear_en) begin
                r_clear_addr <= r_clear_addr + AW'(1);
            end
            r_column          <= n_column;
            r_page            <= n_page;
            r_start_line      <= n_start_line;
            r_display_on      <= n_display_on;
            r_all_on          <= n_all_on;
            r_seg_rev         <= n_seg_rev;
            r_com_rev         <= n_com_rev;
            r_modify          <= n_modify;
            r_expect_contrast <= n_expect_contrast;
            r_contrast        <= n_contrast;
            r_rsp_valid       <= i_cmd.accept;
            r_rsp_kind        <= n_rsp_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit_sel <= line[2:0];
    end

    lcc_ram #(
        .WIDTH (8),
        .DEPTH (lcc_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_status.clear_last = (r_clear_addr == lcc_pkg::LAST_ADDR);
    assign o_strobe            = r_rsp_valid;

    always_comb begin
        o_result.read_data      = 8'h00;
        o_result.pixel_on       = 1'b0;
        o_result.contrast_level = r_contrast;
        case (r_rsp_kind)
            lcc_pkg::RSP_READ: begin
                o_result.read_data = ram_rdata;
            end
            lcc_pkg::RSP_PIXEL_RAM: begin
                o_result.pixel_on = ram_rdata[r_bit_sel];
            end
            lcc_pkg::RSP_PIXEL_ONE: begin
                o_result.pixel_on = 1'b1;
            end
            default: begin
                o_result.read_data = lcc_pkg::STATUS_VALUE;
            end
        endcase
    end

endmodule

/* rtl/lcd_controller_command_and_ram.sv */
// ----------------------------------------------------------------------------
// lcd_controller_command_and_ram
// Page-addressed monochrome LCD controller: command decode, display RAM of
// 9 pages by 132 columns, data and status reads, and pixel queries.
//
//   channel   handshake         payload
//   -------   ---------------   -------------------------------------
//   item in   start / busy      i_cmd    (mode, data byte, row, column)
//   result    o_strobe          o_result (read data, pixel, contrast)
//
// One item per cycle: the single display RAM port does one read or write
// per item, and the result appears in the cycle after acceptance, for one cycle.
// After reset busy stays high while the whole display RAM is swept to zero.
// Results cannot be held off; the next item may be taken in the result cycle.
// ----------------------------------------------------------------------------
module lcd_controller_command_and_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lcc_pkg::t_in_item  i_cmd,
    output logic               o_strobe,
    output lcc_pkg::t_out_item o_result
);

    lcc_pkg::t_dp_cmd    dp_cmd;
    lcc_pkg::t_dp_status dp_status;

    lcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    lcc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_cmd),
        .o_status (dp_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page-addressed LCD controller. Commands, data
// writes and reads, status reads and pixel queries are sent through the
// start/busy port. Expected results come from a cycle-free model of the
// command decoder and display RAM, and each strobed result is compared
// with them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lcc_pkg::*;

    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          TRAFFIC_ITEMS = 440;
    localparam int          NOISE_ITEMS   = 60;
    localparam logic [2:0]  MODE_RESERVED = 3'd7;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_cmd   = '0;
    logic      o_strobe;
    t_out_item o_result;

    lcd_controller_command_and_ram i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // controller image
    logic [7:0]  ram_image [RAM_DEPTH];
    logic [7:0]  col_ptr;
    logic [3:0]  page_ptr;
    logic [5:0]  first_line;
    logic        lcd_enabled;
    logic        all_pixels_on;
    logic        seg_flip;
    logic        com_flip;
    logic        rmw_active;
    logic        contrast_armed;
    logic [5:0]  contrast_now;

    t_out_item   pending_responses [$];
    int          fail_count;
    int          items_sent;
    int          results_seen;
    int          dark_pixels;
    int          cycle_count;
    int          burst_left;
    logic        start_high;

    function automatic int ram_slot();
        return int'(page_ptr) * RAM_COLUMNS + int'(col_ptr);
    endfunction

    function automatic void apply_command(input logic [7:0] d);
        if (d == CMD_DISPLAY_OFF || d == CMD_DISPLAY_ON) begin
            lcd_enabled = d[0];
        end else if (d >= CMD_START_LO && d <= CMD_START_HI) begin
            first_line = d[5:0];
        end else if (d <= CMD_COL_LOW_HI) begin
            col_ptr = {col_ptr[7:4], d[3:0]};
            if (col_ptr > LAST_COLUMN) col_ptr = LAST_COLUMN;
        end else if (d >= CMD_COL_HIGH_LO && d <= CMD_COL_HIGH_HI) begin
            col_ptr = {d[3:0], col_ptr[3:0]};
            if (col_ptr > LAST_COLUMN) col_ptr = LAST_COLUMN;
        end else if (d >= CMD_PAGE_LO && d <= CMD_PAGE_HI) begin
            page_ptr = d[3:0];
            if (page_ptr > LAST_PAGE) page_ptr = LAST_PAGE;
        end else if (d == CMD_SEG_NORMAL || d == CMD_SEG_REVERSE) begin
            seg_flip = d[0];
        end else if (d == CMD_ALL_ON_OFF || d == CMD_ALL_ON_ON) begin
            all_pixels_on = d[0];
        end else if (d == CMD_RMW_BEGIN) begin
            rmw_active = 1'b1;
        end else if (d == CMD_RMW_END) begin
            rmw_active = 1'b0;
        end else if (d >= CMD_COM_LO && d <= CMD_COM_HI) begin
            com_flip = d[3];
        end else if (d == CMD_CONTRAST) begin
            contrast_armed = 1'b1;
        end
    endfunction

    function automatic t_out_item controller_response(input t_in_item it);
        t_out_item  r;
        logic [7:0] d;
        logic [5:0] line;
        int         ram_col;
        r = '0;
        d = it.data_byte;
        if ((it.mode == MODE_CMD_WRITE || it.mode == MODE_DATA_WRITE) && contrast_armed) begin
            contrast_now   = d[5:0];
            contrast_armed = 1'b0;
        end else if (it.mode == MODE_CMD_WRITE) begin
            apply_command(d);
        end else if (it.mode == MODE_DATA_WRITE) begin
            if (page_ptr >= LAST_PAGE) d = d & 8'h01;
            ram_image[ram_slot()] = d;
            if (col_ptr < LAST_COLUMN) col_ptr++;
        end else if (it.mode == MODE_STATUS_READ) begin
            r.read_data = STATUS_VALUE;
        end else if (it.mode == MODE_DATA_READ) begin
            r.read_data = ram_image[ram_slot()];
            if (!rmw_active && col_ptr < LAST_COLUMN) col_ptr++;
        end else if (it.mode == MODE_PIXEL_QUERY) begin
            if (!lcd_enabled) begin
                r.pixel_on = 1'b0;
            end else if (all_pixels_on) begin
                r.pixel_on = 1'b1;
            end else if (int'(it.pixel_column) < VISIBLE_WIDTH) begin
                line    = (com_flip ? 6'(63 - it.pixel_row) : it.pixel_row) + first_line;
                ram_col = seg_flip ? int'(LAST_COLUMN) - int'(it.pixel_column)
                                   : int'(it.pixel_column);
                if (ram_col >= 0 && ram_col < RAM_COLUMNS)
                    r.pixel_on = ram_image[int'(line[5:3]) * RAM_COLUMNS + ram_col][line[2:0]];
            end
        end
        r.contrast_level = contrast_now;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (o_result.pixel_on) dark_pixels++;
            if (pending_responses.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_result.read_data !== want.read_data) begin
                    $error("read_data expected %0d got %0d", want.read_data, o_result.read_data);
                    fail_count++;
                end
                if (o_result.pixel_on !== want.pixel_on) begin
                    $error("pixel_on expected %0d got %0d", want.pixel_on, o_result.pixel_on);
                    fail_count++;
                end
                if (o_result.contrast_level !== want.contrast_level) begin
                    $error("contrast_level expected %0d got %0d",
                           want.contrast_level, o_result.contrast_level);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[lcd_controller_command_and_ram] ERROR");
            $finish;
        end
    end

    function automatic t_in_item random_item();
        t_in_item it;
        it = t_in_item'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        i_cmd      <= it;
        start      <= 1'b1;
        start_high  = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_responses.push_back(controller_response(it));
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 6);
            start     <= 1'b0;
            start_high = 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    task automatic send_mode(input logic [2:0] mode, input logic [7:0] d);
        t_in_item it;
        it           = random_item();
        it.mode      = mode;
        it.data_byte = d;
        send_item(it);
    endtask

    task automatic send_query(input logic [5:0] row, input logic [6:0] col);
        t_in_item it;
        it              = random_item();
        it.mode         = MODE_PIXEL_QUERY;
        it.pixel_row    = row;
        it.pixel_column = col;
        send_item(it);
    endtask

    task automatic test_directed();
        send_mode(MODE_STATUS_READ, 8'hFF);
        send_mode(MODE_DATA_READ, 8'h00);
        send_mode(MODE_CMD_WRITE, CMD_CONTRAST);
        send_mode(MODE_DATA_WRITE, 8'hFF);
        send_mode(MODE_CMD_WRITE, CMD_CONTRAST);
        send_mode(MODE_DATA_READ, 8'h00);
        send_query(6'd0, 7'd0);
        send_mode(MODE_CMD_WRITE, CMD_COL_LOW_LO);
        send_mode(MODE_CMD_WRITE, CMD_PAGE_HI);
        send_mode(MODE_CMD_WRITE, CMD_COL_HIGH_HI);
        send_mode(MODE_DATA_WRITE, 8'hFF);
        send_mode(MODE_DATA_READ, 8'h00);
        send_mode(MODE_CMD_WRITE, CMD_RMW_BEGIN);
        send_mode(MODE_DATA_READ, 8'h00);
        send_mode(MODE_DATA_READ, 8'h00);
        send_mode(MODE_CMD_WRITE, CMD_RMW_END);
        send_mode(MODE_CMD_WRITE, CMD_PAGE_LO);
        send_mode(MODE_CMD_WRITE, CMD_COL_HIGH_LO);
        send_mode(MODE_DATA_WRITE, 8'hA5);
        send_mode(MODE_CMD_WRITE, CMD_DISPLAY_ON);
        send_query(6'd0, 7'd0);
        send_mode(MODE_CMD_WRITE, CMD_ALL_ON_ON);
        send_query(6'd63, 7'd127);
        send_mode(MODE_CMD_WRITE, CMD_ALL_ON_OFF);
        send_mode(MODE_CMD_WRITE, CMD_SEG_REVERSE);
        send_mode(MODE_CMD_WRITE, CMD_COM_HI);
        send_mode(MODE_CMD_WRITE, CMD_START_HI);
        send_query(6'd63, 7'd95);
        send_query(6'd0, 7'd96);
        send_mode(MODE_RESERVED, 8'hFF);
        send_mode(MODE_CMD_WRITE, CMD_DISPLAY_OFF);
        send_query(6'd63, 7'd0);
    endtask

    task automatic set_address();
        logic [3:0] page_sel;
        logic [3:0] col_hi;
        page_sel = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        col_hi   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        send_mode(MODE_CMD_WRITE, CMD_PAGE_LO | 8'(page_sel));
        send_mode(MODE_CMD_WRITE, CMD_COL_HIGH_LO | 8'(col_hi));
        send_mode(MODE_CMD_WRITE, CMD_COL_LOW_LO | 8'($urandom_range(0, 15)));
    endtask

    task automatic send_setup();
        case ($urandom_range(0, 5))
            0: send_mode(MODE_CMD_WRITE, ($urandom_range(0, 4) == 0) ? CMD_DISPLAY_OFF
                                                                      : CMD_DISPLAY_ON);
            1: send_mode(MODE_CMD_WRITE, ($urandom_range(0, 6) == 0) ? CMD_ALL_ON_ON
                                                                      : CMD_ALL_ON_OFF);
            2: send_mode(MODE_CMD_WRITE, $urandom_range(0, 1) ? CMD_SEG_REVERSE
                                                               : CMD_SEG_NORMAL);
            3: send_mode(MODE_CMD_WRITE, CMD_COM_LO | 8'($urandom_range(0, 15)));
            4: send_mode(MODE_CMD_WRITE, CMD_START_LO | 8'($urandom_range(0, 63)));
            default: send_mode(MODE_CMD_WRITE, CMD_RMW_END);
        endcase
    endtask

    task automatic test_addressed_traffic();
        int stop_at;
        int n;
        stop_at = items_sent + TRAFFIC_ITEMS;
        send_mode(MODE_CMD_WRITE, CMD_DISPLAY_ON);
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    set_address();
                    n = $urandom_range(1, 12);
                    repeat (n) send_mode(MODE_DATA_WRITE, 8'($urandom));
                end
                2: begin
                    set_address();
                    if ($urandom_range(0, 2) == 0) send_mode(MODE_CMD_WRITE, CMD_RMW_BEGIN);
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_mode(MODE_DATA_READ, 8'($urandom));
                        if ($urandom_range(0, 3) == 0) send_mode(MODE_DATA_WRITE, 8'($urandom));
                    end
                    send_mode(MODE_CMD_WRITE, CMD_RMW_END);
                end
                3: send_setup();
                4, 5, 6: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_query(6'($urandom),
                                          ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                                      : 7'($urandom_range(0, 95)));
                end
                7: begin
                    send_mode(MODE_CMD_WRITE, CMD_CONTRAST);
                    if ($urandom_range(0, 2) == 0) send_mode(MODE_STATUS_READ, 8'($urandom));
                    send_mode($urandom_range(0, 1) ? MODE_DATA_WRITE : MODE_CMD_WRITE,
                              8'($urandom));
                end
                default: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(random_item());
                end
            endcase
        end
    endtask

    task automatic test_raw_noise();
        repeat (NOISE_ITEMS) send_item(random_item());
    endtask

    initial begin
        foreach (ram_image[k]) ram_image[k] = 8'h00;
        col_ptr        = '0;
        page_ptr       = '0;
        first_line     = '0;
        lcd_enabled    = 1'b0;
        all_pixels_on  = 1'b0;
        seg_flip       = 1'b0;
        com_flip       = 1'b0;
        rmw_active     = 1'b0;
        contrast_armed = 1'b0;
        contrast_now   = '0;
        fail_count     = 0;
        items_sent     = 0;
        results_seen   = 0;
        dark_pixels    = 0;
        cycle_count    = 0;
        burst_left     = 40;
        start_high     = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_addressed_traffic();
        test_raw_noise();

        if (start_high) start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("covered %0d items (commands, writes, reads, status, pixel queries)", items_sent);
        $display("checked %0d results, %0d of them dark pixels", results_seen, dark_pixels);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("[lcd_controller_command_and_ram] OK");
        end else begin
            $display("[lcd_controller_command_and_ram] ERROR");
        end
        $finish;
    end

endmodule
